// ===== design/psd_pkg.sv =====
// psd_pkg: shared constants for the point to segment distance core
// no dependencies; used by the interfaces and the core top level
package psd_pkg;

   // default coordinate width and its allowed span
   localparam int COORD_BITS_DEF = 16;
   localparam int COORD_BITS_MIN = 8;
   localparam int COORD_BITS_MAX = 24;

   // projection parameter fraction bits (1.0 = 2^T_FRAC)
   localparam int T_FRAC = 16;

   // result format
   localparam int DIST_WIDTH = 25;
   localparam int DIST_FRAC  = 8;

endpackage

// ===== design/psd_chan_if.sv =====
// psd_chan_if: valid/ready channels of the point to segment distance core
// depends on psd_pkg for default widths
interface psd_req_if #(
   parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] seg_start_x;
   logic signed [COORD_BITS-1:0] seg_start_y;
   logic signed [COORD_BITS-1:0] seg_end_x;
   logic signed [COORD_BITS-1:0] seg_end_y;
   logic signed [COORD_BITS-1:0] query_x;
   logic signed [COORD_BITS-1:0] query_y;

   modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                   query_x, query_y, input ready);
   modport sink   (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                   query_x, query_y, output ready);
endinterface

interface psd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [psd_pkg::DIST_WIDTH-1:0]    distance;

   modport source (output valid, distance, input ready);
   modport sink   (input valid, distance, output ready);
endinterface

// ===== design/psd_div.sv =====
// psd_div: pipelined restoring divider, one quotient bit per stage
// depends on nothing but its parameters; instantiated by the core top level
module psd_div #(
   parameter int DW    = 34,
   parameter int STEPS = 16,
   parameter int PAYW  = 68
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [DW-1:0]    in_rem,
   input  logic [DW-1:0]    in_den,
   input  logic             in_sat,
   input  logic [PAYW-1:0]  in_pay,
   output logic             out_valid,
   output logic [STEPS-1:0] out_q,
   output logic             out_sat,
   output logic [PAYW-1:0]  out_pay
);

   logic             v_ff   [STEPS];
   logic [DW-1:0]    rem_ff [STEPS];
   logic [DW-1:0]    den_ff [STEPS];
   logic [STEPS-1:0] q_ff   [STEPS];
   logic             sat_ff [STEPS];
   logic [PAYW-1:0]  pay_ff [STEPS];

   for (genvar g = 0; g < STEPS; g++) begin : g_stage
      logic             v_src;
      logic [DW-1:0]    rem_src;
      logic [DW-1:0]    den_src;
      logic [STEPS-1:0] q_src;
      logic             sat_src;
      logic [PAYW-1:0]  pay_src;
      logic [DW:0]      rem2;
      logic [DW:0]      diff;
      logic             ge;

      if (g == 0) begin : g_first
         assign v_src   = in_valid;
         assign rem_src = in_rem;
         assign den_src = in_den;
         assign q_src   = '0;
         assign sat_src = in_sat;
         assign pay_src = in_pay;
      end else begin : g_next
         assign v_src   = v_ff[g-1];
         assign rem_src = rem_ff[g-1];
         assign den_src = den_ff[g-1];
         assign q_src   = q_ff[g-1];
         assign sat_src = sat_ff[g-1];
         assign pay_src = pay_ff[g-1];
      end

      // trial subtract of the doubled remainder
      always_comb begin
         rem2 = {rem_src, 1'b0};
         diff = rem2 - {1'b0, den_src};
         ge   = (rem2 >= {1'b0, den_src});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (en) begin
            v_ff[g] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g] <= ge ? diff[DW-1:0] : rem2[DW-1:0];
            den_ff[g] <= den_src;
            q_ff[g]   <= {q_src[STEPS-2:0], ge};
            sat_ff[g] <= sat_src;
            pay_ff[g] <= pay_src;
         end
      end
   end

   assign out_valid = v_ff[STEPS-1];
   assign out_q     = q_ff[STEPS-1];
   assign out_sat   = sat_ff[STEPS-1];
   assign out_pay   = pay_ff[STEPS-1];

endmodule

// ===== design/psd_sqrt.sv =====
// psd_sqrt: pipelined integer square root, one root bit per stage
// depends on nothing but its parameter; instantiated by the core top level
module psd_sqrt #(
   parameter int R = 37
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  logic [2*R-1:0] in_s,
   output logic           out_valid,
   output logic [R-1:0]   out_root
);

   logic           v_ff    [R];
   logic [2*R-1:0] s_ff    [R];
   logic [R+1:0]   rem_ff  [R];
   logic [R-1:0]   root_ff [R];

   for (genvar k = 0; k < R; k++) begin : g_stage
      logic           v_src;
      logic [2*R-1:0] s_src;
      logic [R+1:0]   rem_src;
      logic [R-1:0]   root_src;
      logic [R+3:0]   remc;
      logic [R+3:0]   trial;
      logic           ge;

      if (k == 0) begin : g_first
         assign v_src    = in_valid;
         assign s_src    = in_s;
         assign rem_src  = '0;
         assign root_src = '0;
      end else begin : g_next
         assign v_src    = v_ff[k-1];
         assign s_src    = s_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
      end

      // bring down two bits and try 4*root + 1
      always_comb begin
         remc  = {rem_src, s_src[2*R-1 -: 2]};
         trial = {2'b00, root_src, 2'b01};
         ge    = (remc >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            s_ff[k]    <= {s_src[2*R-3:0], 2'b00};
            rem_ff[k]  <= ge ? (R+2)'(remc - trial) : remc[R+1:0];
            root_ff[k] <= {root_src[R-2:0], ge};
         end
      end
   end

   assign out_valid = v_ff[R-1];
   assign out_root  = root_ff[R-1];

endmodule

// ===== design/point_segment_distance_core.sv =====
// Point to segment distance core. Accepts one query per cycle (segment endpoints A, B and a
// point P) and returns floor(sqrt(|E|^2)/256) with 8 fraction bits, where E is P - A minus
// t*(B - A) and t is the projection clamped to [0,1] with 16 fraction bits. The pipeline has
// three front stages for differences, products and sums, sixteen divider stages (one quotient
// bit each), five residual and squaring stages, COORD_BITS + 21 square root stages (one root
// bit each) and the output register. Throughput is one item per cycle; a stall at the result
// side holds the whole pipeline in place. Depends on psd_pkg, psd_chan_if, psd_div and
// psd_sqrt.
module point_segment_distance_core #(
   parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   psd_req_if.sink   req_if,
   psd_rsp_if.source rsp_if
);

   localparam int CW   = COORD_BITS + 1;
   localparam int PW   = 2 * CW;
   localparam int NW   = PW + 1;
   localparam int DW   = PW;
   localparam int TF   = psd_pkg::T_FRAC;
   localparam int ESW  = CW + TF + 3;
   localparam int EW   = ESW;
   localparam int H    = (EW + 1) / 2;
   localparam int HW   = EW - H;
   localparam int R    = EW + 1;
   localparam int SW   = 2 * R;
   localparam int PAYW = 4 * CW;
   localparam int XW   = R + psd_pkg::DIST_WIDTH;

   logic en;

   // whole pipeline advances unless the output holds an untaken result
   logic out_v_ff;
   assign en           = !out_v_ff || rsp_if.ready;
   assign req_if.ready = en;

   // stage 1: differences
   logic                 v1_ff;
   logic signed [CW-1:0] dx1_ff, dy1_ff, qx1_ff, qy1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx1_ff <= CW'(req_if.seg_end_x) - CW'(req_if.seg_start_x);
         dy1_ff <= CW'(req_if.seg_end_y) - CW'(req_if.seg_start_y);
         qx1_ff <= CW'(req_if.query_x) - CW'(req_if.seg_start_x);
         qy1_ff <= CW'(req_if.query_y) - CW'(req_if.seg_start_y);
      end
   end

   // stage 2: dot product and length products
   logic                 v2_ff;
   logic signed [PW-1:0] qdx2_ff, qdy2_ff, ddx2_ff, ddy2_ff;
   logic [PAYW-1:0]      pay2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qdx2_ff <= qx1_ff * dx1_ff;
         qdy2_ff <= qy1_ff * dy1_ff;
         ddx2_ff <= dx1_ff * dx1_ff;
         ddy2_ff <= dy1_ff * dy1_ff;
         pay2_ff <= {qx1_ff, qy1_ff, dx1_ff, dy1_ff};
      end
   end

   // stage 3: numerator and squared length
   logic                 v3_ff;
   logic signed [NW-1:0] num3_ff;
   logic [DW-1:0]        den3_ff;
   logic [PAYW-1:0]      pay3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num3_ff <= NW'(qdx2_ff) + NW'(qdy2_ff);
         den3_ff <= DW'($unsigned(ddx2_ff)) + DW'($unsigned(ddy2_ff));
         pay3_ff <= pay2_ff;
      end
   end

   // clamp decision: zero and full-scale cases bypass the quotient
   logic          t_zero, t_sat;
   logic [DW-1:0] div_rem, div_den;

   always_comb begin
      t_zero  = (den3_ff == '0) || (num3_ff <= NW'(0));
      t_sat   = !t_zero && ($unsigned(num3_ff) >= {1'b0, den3_ff});
      div_rem = (t_zero || t_sat) ? '0 : num3_ff[DW-1:0];
      div_den = (t_zero || t_sat) ? DW'(1) : den3_ff;
   end

   logic            div_v;
   logic [TF-1:0]   div_q;
   logic            div_sat;
   logic [PAYW-1:0] div_pay;

   psd_div #(
      .DW    (DW),
      .STEPS (TF),
      .PAYW  (PAYW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_rem    (div_rem),
      .in_den    (div_den),
      .in_sat    (t_sat),
      .in_pay    (pay3_ff),
      .out_valid (div_v),
      .out_q     (div_q),
      .out_sat   (div_sat),
      .out_pay   (div_pay)
   );

   // stage t: closest point offset t*d
   logic                  t_v;
   logic [TF:0]           t_val;
   logic signed [CW-1:0]  pqx, pqy, pdx, pdy;
   logic                  vt_ff;
   logic signed [ESW-1:0] tdx_ff, tdy_ff;
   logic signed [CW-1:0]  qxt_ff, qyt_ff;

   always_comb begin
      {pqx, pqy, pdx, pdy} = div_pay;
      t_val = div_sat ? (TF+1)'(1) << TF : {1'b0, div_q};
      t_v   = div_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vt_ff <= 1'b0;
      end else if (en) begin
         vt_ff <= t_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tdx_ff <= ESW'($signed({1'b0, t_val}) * pdx);
         tdy_ff <= ESW'($signed({1'b0, t_val}) * pdy);
         qxt_ff <= pqx;
         qyt_ff <= pqy;
      end
   end

   // stage e: residual magnitudes
   logic signed [ESW-1:0] ex, ey;
   logic                  ve_ff;
   logic [EW-1:0]         ax_ff, ay_ff;

   always_comb begin
      ex = (ESW'(qxt_ff) <<< TF) - tdx_ff;
      ey = (ESW'(qyt_ff) <<< TF) - tdy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else if (en) begin
         ve_ff <= vt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff <= ex[ESW-1] ? EW'(-ex) : EW'(ex);
         ay_ff <= ey[ESW-1] ? EW'(-ey) : EW'(ey);
      end
   end

   // stage p: partial products of the squares
   logic              vp_ff;
   logic [2*HW-1:0]   xhh_ff, yhh_ff;
   logic [HW+H-1:0]   xhl_ff, yhl_ff;
   logic [2*H-1:0]    xll_ff, yll_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
      end else if (en) begin
         vp_ff <= ve_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xhh_ff <= ax_ff[EW-1:H] * ax_ff[EW-1:H];
         xhl_ff <= ax_ff[EW-1:H] * ax_ff[H-1:0];
         xll_ff <= ax_ff[H-1:0] * ax_ff[H-1:0];
         yhh_ff <= ay_ff[EW-1:H] * ay_ff[EW-1:H];
         yhl_ff <= ay_ff[EW-1:H] * ay_ff[H-1:0];
         yll_ff <= ay_ff[H-1:0] * ay_ff[H-1:0];
      end
   end

   // stage a: each square assembled
   logic          va_ff;
   logic [SW-1:0] sqx_ff, sqy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= vp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff <= (SW'(xhh_ff) << (2*H)) + (SW'(xhl_ff) << (H+1)) + SW'(xll_ff);
         sqy_ff <= (SW'(yhh_ff) << (2*H)) + (SW'(yhl_ff) << (H+1)) + SW'(yll_ff);
      end
   end

   // stage b: squared distance
   logic          vb_ff;
   logic [SW-1:0] ssum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (en) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ssum_ff <= sqx_ff + sqy_ff;
      end
   end

   logic         sq_v;
   logic [R-1:0] sq_root;

   psd_sqrt #(
      .R (R)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vb_ff),
      .in_s      (ssum_ff),
      .out_valid (sq_v),
      .out_root  (sq_root)
   );

   // output register: drop fraction bits beyond the result and saturate
   logic [XW-1:0]                   rt_x;
   logic [psd_pkg::DIST_WIDTH-1:0]  dist_in;
   logic [psd_pkg::DIST_WIDTH-1:0]  dist_ff;

   always_comb begin
      rt_x = XW'(sq_root) >> psd_pkg::DIST_FRAC;
      if (rt_x > XW'({psd_pkg::DIST_WIDTH{1'b1}})) begin
         dist_in = '1;
      end else begin
         dist_in = rt_x[psd_pkg::DIST_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= sq_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff <= dist_in;
      end
   end

   assign rsp_if.valid    = out_v_ff;
   assign rsp_if.distance = dist_ff;

   // a clamped item carries no quotient bits out of the divider
   a_sat_no_q : assert property (@(posedge clock) disable iff (reset)
      div_v && div_sat |-> div_q == '0)
      else $error("clamped item left a quotient");

   // an accepted transfer enters the first stage
   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> v1_ff)
      else $error("accepted transfer lost at the first stage");

   // a held pipeline keeps the root stage unchanged
   a_hold_root : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(sq_root) && $stable(sq_v))
      else $error("root stage moved during a stall");

   // a zero length segment never takes the full-scale projection
   a_zero_not_sat : assert property (@(posedge clock) disable iff (reset)
      v3_ff && den3_ff == '0 |-> !t_sat)
      else $error("degenerate segment clamped to the far end");

endmodule
